FILE: hdl/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg - shared types and constants for the hex record stream parser
// Holds the phase codes, status codes, record type codes, the result
// struct and the ASCII hex digit decoder.
// ----------------------------------------------------------------------------
package hrsp_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_AHI  = 3'd2;
   localparam logic [2:0] PH_ALO  = 3'd3;
   localparam logic [2:0] PH_TYPE = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_SUM  = 3'd6;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Record-end status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SUM  = 2'd1;
   localparam logic [1:0] ST_BAD_TYPE = 2'd2;
   localparam logic [1:0] ST_FORMAT   = 2'd3;

   // Record type codes
   localparam logic [7:0] REC_DATA    = 8'd0;
   localparam logic [7:0] REC_EOF     = 8'd1;
   localparam logic [7:0] REC_SEGMENT = 8'd2;
   localparam logic [7:0] REC_LINEAR  = 8'd4;

   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Result word width on the stream, padded to whole bytes
   localparam int unsigned RSP_DATA_W = 80;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_address;
      logic [7:0]  record_kind;
      logic [7:0]  record_len;
      logic [15:0] record_addr;
      logic [15:0] extended_offset;
      logic [1:0]  status;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Decode one ASCII hex digit, either case
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.ok    = 1'b0;
      d.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         d.ok    = 1'b1;
         d.value = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         d.ok    = 1'b1;
         d.value = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

FILE: hdl/hrsp_parser.sv
// ----------------------------------------------------------------------------
// hrsp_parser - record state machine of the hex record stream parser
// Advances the record state by one character per step and forms the
// result of that character, if any, for the output register.
// ----------------------------------------------------------------------------
module hrsp_parser
   import hrsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_code,
   output logic       produced,
   output result_type result
);

   logic [2:0]  phase_ff, phase_in;
   logic        pending_ff, pending_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] address_ff, address_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  done_ff, done_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] offset_ff, offset_in;

   hex_digit_type digit;
   logic [7:0]    byte_val;
   logic [7:0]    done_next;
   logic          offset_kind;
   logic          known_kind;

   assign digit       = hex_decode(char_code);
   assign byte_val    = {high_nibble_ff, digit.value};
   assign done_next   = done_ff + 8'd1;
   assign offset_kind = (type_ff == REC_SEGMENT) || (type_ff == REC_LINEAR);
   assign known_kind  = (type_ff == REC_DATA) || (type_ff == REC_EOF) || offset_kind;

   // Next state and result for one character
   always_comb begin
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      high_nibble_in = high_nibble_ff;
      length_in      = length_ff;
      address_in     = address_ff;
      type_in        = type_ff;
      done_in        = done_ff;
      sum_in         = sum_ff;
      offset_in      = offset_ff;
      produced       = 1'b0;

      // record-end summary by default; data bytes override below
      result.kind            = KIND_END;
      result.data_byte       = 8'd0;
      result.byte_address    = 16'd0;
      result.record_kind     = type_ff;
      result.record_len      = length_ff;
      result.record_addr     = address_ff;
      result.extended_offset = offset_kind ? offset_ff : 16'd0;
      result.status          = ST_FORMAT;

      if (step) begin
         if (phase_ff == PH_HUNT || phase_ff > PH_SUM) begin
            // hunt for the colon, drop everything else
            phase_in = PH_HUNT;
            if (char_code == CHAR_COLON) begin
               phase_in       = PH_LEN;
               pending_in     = 1'b0;
               high_nibble_in = 4'd0;
               length_in      = 8'd0;
               address_in     = 16'd0;
               type_in        = 8'd0;
               done_in        = 8'd0;
               sum_in         = 8'd0;
               offset_in      = 16'd0;
            end
         end else if (!digit.ok) begin
            // format error: report what was decoded and resync
            produced   = 1'b1;
            phase_in   = PH_HUNT;
            pending_in = 1'b0;
         end else if (!pending_ff) begin
            high_nibble_in = digit.value;
            pending_in     = 1'b1;
         end else begin
            pending_in = 1'b0;
            sum_in     = sum_ff + byte_val;
            case (phase_ff)
               PH_LEN: begin
                  length_in = byte_val;
                  phase_in  = PH_AHI;
               end
               PH_AHI: begin
                  address_in = {byte_val, 8'd0};
                  phase_in   = PH_ALO;
               end
               PH_ALO: begin
                  address_in = {address_ff[15:8], byte_val};
                  phase_in   = PH_TYPE;
               end
               PH_TYPE: begin
                  type_in  = byte_val;
                  phase_in = (length_ff == 8'd0) ? PH_SUM : PH_DATA;
               end
               PH_DATA: begin
                  // capture the offset word from the first two payload bytes
                  if (done_ff == 8'd0) begin
                     offset_in = {byte_val, 8'd0};
                  end else if (done_ff == 8'd1) begin
                     offset_in = {offset_ff[15:8], byte_val};
                  end
                  if (type_ff == REC_DATA) begin
                     produced               = 1'b1;
                     result.kind            = KIND_DATA;
                     result.data_byte       = byte_val;
                     result.byte_address    = address_ff + {8'd0, done_ff};
                     result.extended_offset = 16'd0;
                     result.status          = ST_OK;
                  end
                  done_in = done_next;
                  if (done_next == length_ff) begin
                     phase_in = PH_SUM;
                  end
               end
               PH_SUM: begin
                  produced = 1'b1;
                  phase_in = PH_HUNT;
                  if (sum_in != 8'd0) begin
                     result.status = ST_BAD_SUM;
                  end else if (!known_kind) begin
                     result.status = ST_BAD_TYPE;
                  end else begin
                     result.status = ST_OK;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   // Hold record state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         pending_ff     <= 1'b0;
         high_nibble_ff <= 4'd0;
         length_ff      <= 8'd0;
         address_ff     <= 16'd0;
         type_ff        <= 8'd0;
         done_ff        <= 8'd0;
         sum_ff         <= 8'd0;
         offset_ff      <= 16'd0;
      end else begin
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         high_nibble_ff <= high_nibble_in;
         length_ff      <= length_in;
         address_ff     <= address_in;
         type_ff        <= type_in;
         done_ff        <= done_in;
         sum_ff         <= sum_in;
         offset_ff      <= offset_in;
      end
   end

   // Junk outside a record leaves the parser hunting
   a_hunt_holds: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_HUNT && char_code != CHAR_COLON |=> phase_ff == PH_HUNT)
      else $error("parser left hunting without a colon");

   // Every record end returns to hunting
   a_end_to_hunt: assert property (@(posedge clock) disable iff (reset)
      produced && result.kind == KIND_END |=> phase_ff == PH_HUNT && !pending_ff)
      else $error("record end did not return to hunting");

   // Data bytes come only from the payload of a data record
   a_data_in_payload: assert property (@(posedge clock) disable iff (reset)
      produced && result.kind == KIND_DATA |-> phase_ff == PH_DATA && type_ff == REC_DATA)
      else $error("data byte outside a data record payload");

   // No half byte is pending while hunting
   a_hunt_no_nibble: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> !pending_ff)
      else $error("nibble pending while hunting");

endmodule

FILE: hdl/hex_record_stream_parser_core.sv
// ----------------------------------------------------------------------------
// hex_record_stream_parser_core - hex record stream parser, top level
// Path: a result word reaches rsp_ from its accepted character through the
//   input register, then the parse into the result register.
// Throughput: one character word per cycle while rsp_ is not back-pressured, set by the single parse stage.
// Reset: synchronous; empties both registers and returns the parser to
//   hunting for a colon.
// ----------------------------------------------------------------------------
module hex_record_stream_parser_core
   import hrsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_code
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // data_byte, byte_address, record_kind,
                                              // record_len, record_addr,
                                              // extended_offset, status, zero pad
   output logic                  rsp_tuser    // kind
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       step;
   logic       produced;
   result_type result;

   // Parse the held word when the result register can take its result
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   hrsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .char_code (in_char_ff),
      .produced  (produced),
      .result    (result)
   );

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !step);
   assign out_valid_in = (step && produced) || (out_valid_ff && !rsp_tready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && produced) begin
         out_ff <= result;
      end
   end

   // Pack the result word
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {6'd0, out_ff.status, out_ff.extended_offset, out_ff.record_addr,
                        out_ff.record_len, out_ff.record_kind, out_ff.byte_address,
                        out_ff.data_byte};

endmodule
